// ===== src/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int PATTERN_MAX_DEFAULT = 16;

  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 64;
  localparam int CARE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int PAT_BYTES  = 16;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  // register index, taken from paddr[5:3]
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_REGION_BASE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] pattern_low;
    logic [DATA_W-1:0] pattern_high;
    logic [CARE_W-1:0] care_mask;
    logic [LEN_W-1:0]  pattern_length;
    logic [ADDR_W-1:0] region_base;
  } scan_cfg_t;

  // one pending result from the matcher
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] start_offset;
  } scan_hit_t;

endpackage

`default_nettype wire

// ===== src/wbps_byte_if.sv =====
// ----------------------------------------------------------------------------
// wbps_byte_if
// Byte stream channel: one region byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== src/wbps_result_if.sv =====
// ----------------------------------------------------------------------------
// wbps_result_if
// Result channel: found flag and match address per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

// ===== src/wbps_regs.sv =====
// ----------------------------------------------------------------------------
// wbps_regs
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_regs
  import wbps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready,
  output scan_cfg_t                  cfg
);

  scan_cfg_t cfg_q;
  reg_idx_t  reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LOW:  cfg_q.pattern_low    <= pwdata;
        REG_PATTERN_HIGH: cfg_q.pattern_high   <= pwdata;
        REG_CARE_MASK:    cfg_q.care_mask      <= pwdata[CARE_W-1:0];
        REG_PATTERN_LEN:  cfg_q.pattern_length <= pwdata[LEN_W-1:0];
        REG_REGION_BASE:  cfg_q.region_base    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LOW:  prdata = cfg_q.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg_q.pattern_high;
      REG_CARE_MASK:    prdata = {{(DATA_W-CARE_W){1'b0}}, cfg_q.care_mask};
      REG_PATTERN_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.pattern_length};
      REG_REGION_BASE:  prdata = cfg_q.region_base;
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/wbps_matcher.sv =====
// ----------------------------------------------------------------------------
// wbps_matcher
// Input register, byte window and masked parallel compare of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_matcher
  import wbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire scan_cfg_t cfg,
  wbps_byte_if.sink      bytes,
  output logic           hit_valid,
  input  wire logic      hit_ready,
  output scan_hit_t      hit
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  // input register
  logic       s0_valid;
  logic [7:0] s0_data;
  logic       s0_last;
  logic       s0_go;

  // scan state
  logic [7:0]        window      [PATTERN_MAX];
  logic [7:0]        window_next [PATTERN_MAX];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [ADDR_W-1:0] position;
  logic [ADDR_W-1:0] position_next;
  logic              reported;

  // result register toward the address stage
  logic      s1_valid;
  scan_hit_t s1_hit;
  logic      s1_free;

  logic                   matched;
  logic                   emit;
  logic [8*PAT_BYTES-1:0] pattern;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};

  assign s1_free     = !s1_valid || hit_ready;
  assign s0_go       = s0_valid && s1_free;
  assign bytes.ready = !s0_valid || s1_free;

  assign hit_valid = s1_valid;
  assign hit       = s1_hit;

  always_comb begin
    window_next[0] = s0_data;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign fill_next     = (fill == FILL_W'(PATTERN_MAX)) ? fill : fill + 1'b1;
  assign position_next = position + 1'b1;

  // pattern byte j lines up with window entry length-1-j
  always_comb begin
    logic [LEN_W-1:0] idx;
    logic [7:0]       sel;
    logic             ok;
    ok = (cfg.pattern_length != '0) &&
         (cfg.pattern_length <= LEN_W'(PATTERN_MAX)) &&
         (LEN_W'(fill_next) >= cfg.pattern_length);
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx = cfg.pattern_length - LEN_W'(1) - LEN_W'(j);
      sel = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (idx == LEN_W'(k)) begin
          sel = sel | window_next[k];
        end
      end
      if ((LEN_W'(j) < cfg.pattern_length) && cfg.care_mask[j] &&
          (sel != pattern[8*j +: 8])) begin
        ok = 1'b0;
      end
    end
    matched = ok;
  end

  assign emit = !reported && (matched || s0_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      fill     <= '0;
      position <= '0;
      reported <= 1'b0;
    end else begin
      if (bytes.ready) begin
        s0_valid <= bytes.valid;
      end
      if (s1_free) begin
        s1_valid <= s0_go && emit;
      end
      if (s0_go) begin
        if (s0_last) begin
          fill     <= '0;
          position <= '0;
          reported <= 1'b0;
        end else begin
          fill     <= fill_next;
          position <= position_next;
          reported <= reported || matched;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s0_data <= bytes.data_byte;
      s0_last <= bytes.last_byte;
    end
    if (s0_go) begin
      window <= window_next;
    end
    if (s0_go && emit) begin
      s1_hit.found        <= !reported && matched;
      s1_hit.start_offset <= position_next - {{(ADDR_W-LEN_W){1'b0}}, cfg.pattern_length};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(PATTERN_MAX))
    else $error("window fill count above window depth");

  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    s0_go && s0_last |=> fill == '0 && position == '0 && !reported)
    else $error("scan state not cleared after region end");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    s0_go && reported |-> !(s1_free && s1_valid && $past(1'b0)) && !(emit))
    else $error("second result issued within one region");

endmodule

`default_nettype wire

// ===== src/wbps_result.sv =====
// ----------------------------------------------------------------------------
// wbps_result
// Address stage: adds region base to the match offset (address zero when not found) and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_result
  import wbps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire scan_cfg_t cfg,
  input  wire logic      hit_valid,
  output logic           hit_ready,
  input  wire scan_hit_t hit,
  wbps_result_if.source  results
);

  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_address;

  assign hit_ready = !out_valid || results.ready;

  assign results.valid         = out_valid;
  assign results.found         = out_found;
  assign results.match_address = out_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hit_ready) begin
      out_valid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_valid && hit_ready) begin
      out_found   <= hit.found;
      out_address <= hit.found ? cfg.region_base + hit.start_offset : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/wildcard_byte_pattern_scanner_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// Scans a byte stream for a masked pattern and reports, per region, the first match or not found.
// ----------------------------------------------------------------------------
//  channel   dir  transfer payload
//  bytes     in   data_byte[7:0], last_byte
//  results   out  found, match_address[63:0]
//  apb       in   psel/penable/pwrite/paddr[5:0]/pwdata[63:0] -> prdata[63:0]
//
//  one byte per cycle sustained while results are taken; three register stages
//  from byte to result (input register, window compare, address add)
//  rst clears control state and all configuration registers
//  a stalled result holds in its output register while the stages behind it
//  fill up, then bytes.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner_core
  import wbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  wbps_byte_if.sink                  bytes,
  wbps_result_if.source              results,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready
);

  scan_cfg_t cfg;
  logic      hit_valid;
  logic      hit_ready;
  scan_hit_t hit;

  wbps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbps_matcher #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_matcher (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .bytes     (bytes),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit       (hit)
  );

  wbps_result u_result (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit       (hit),
    .results   (results)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_wildcard_byte_pattern_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scanner_core
// Self-checking bench for the byte pattern scanner. Regions of bytes are
// streamed in with random gaps and the result channel is stalled at random.
// A scoreboard keeps its own window of recent bytes and the register copy and
// predicts the found/not-found result of every region, which is compared
// field by field against each result transfer.
// ----------------------------------------------------------------------------

module tb_wildcard_byte_pattern_scanner_core;
  import wbps_pkg::*;

  localparam int         SETTLE_CYCLES    = 8;
  localparam int         RANDOM_BYTES     = 900;
  localparam int         CYCLE_LIMIT      = 500000;
  localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
  } scan_result_t;

  class scan_scoreboard;
    logic [63:0]  pattern_low;
    logic [63:0]  pattern_high;
    logic [15:0]  care_mask;
    logic [4:0]   pattern_length;
    logic [63:0]  region_base;
    logic [7:0]   window [16];
    logic [63:0]  position;
    bit           reported;
    scan_result_t expected_q [$];
    int           errors;

    function new();
      pattern_low    = '0;
      pattern_high   = '0;
      care_mask      = '0;
      pattern_length = '0;
      region_base    = '0;
      errors         = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[i]) window[i] = 8'h00;
      position = '0;
      reported = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_LOW:  pattern_low    = value;
        REG_PATTERN_HIGH: pattern_high   = value;
        REG_CARE_MASK:    care_mask      = value[15:0];
        REG_PATTERN_LEN:  pattern_length = value[4:0];
        REG_REGION_BASE:  region_base    = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(int j);
      logic [127:0] both;
      both = {pattern_high, pattern_low};
      return both[j*8 +: 8];
    endfunction

    // newest byte sits at window[0], so pattern byte j lines up with
    // window[len-1-j]
    function bit window_hit();
      int len;
      len = pattern_length;
      if (len == 0 || len > PATTERN_MAX_DEFAULT) return 1'b0;
      if (position < 64'(len)) return 1'b0;
      for (int j = 0; j < len; j++) begin
        if (care_mask[j] && window[len-1-j] != pattern_byte(j)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      scan_result_t r;
      for (int i = 15; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      position  = position + 64'd1;
      if (!reported && window_hit()) begin
        r.found         = 1'b1;
        r.match_address = region_base + position - 64'(pattern_length);
        expected_q.insert(expected_q.size(), r);
        reported = 1'b1;
      end else if (last && !reported) begin
        r = '0;
        expected_q.insert(expected_q.size(), r);
      end
      if (last) clear_scan();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic found, logic [63:0] addr);
      scan_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result found=%0b address=%h", found, addr));
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found)
        report($sformatf("found %0b, expected %0b", found, want.found));
      if (addr !== want.match_address)
        report($sformatf("match_address %h, expected %h", addr, want.match_address));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  wbps_byte_if   bytes_if ();
  wbps_result_if results_if ();

  scan_scoreboard sb;
  int             cycles;
  int             bytes_sent;

  wildcard_byte_pattern_scanner_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 64'h0;
    if (r < 20) return '1;
    return rand64();
  endfunction

  // valid stays high after a transfer so back-to-back bytes need no extra step
  task send_byte(input logic [7:0] data, input logic last, input bit no_gaps);
    int gap;
    bit accepted;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      bytes_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_if.valid     <= 1'b1;
    bytes_if.data_byte <= data;
    bytes_if.last_byte <= last;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      if (bytes_if.ready) begin
        accepted = 1'b1;
        sb.note_byte(data, last);
      end
      @(negedge clk);
    end
    bytes_sent++;
  endtask

  task wait_drain();
    bytes_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task wait_idle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task cfg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task configure(input int phase);
    logic [63:0] v_len;
    logic [63:0] v_care;
    logic [63:0] v_base;
    int          r;
    v_len  = rand64();
    v_care = rand64();
    if (phase == 0) begin
      // overlong length with all wildcards: would match anywhere if allowed
      v_len[4:0]   = 5'($urandom_range(17, 31));
      v_care[15:0] = 16'h0000;
    end else if (phase == 1) begin
      v_len[4:0]   = 5'd16;
      v_care[15:0] = 16'hFFFF;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8)       v_len[4:0] = 5'd0;
      else if (r < 16) v_len[4:0] = 5'($urandom_range(17, 31));
      else if (r < 26) v_len[4:0] = 5'd16;
      else if (r < 34) v_len[4:0] = 5'd1;
      else             v_len[4:0] = 5'($urandom_range(2, 15));
      r = $urandom_range(0, 99);
      if (r < 10)      v_care[15:0] = 16'h0000;
      else if (r < 25) v_care[15:0] = 16'hFFFF;
    end
    r = $urandom_range(0, 99);
    if (r < 10)      v_base = 64'h0;
    else if (r < 20) v_base = '1;
    else if (r < 30) v_base = {56'hFF_FFFF_FFFF_FFFF, 8'($urandom)};
    else             v_base = rand64();
    cfg_write(REG_PATTERN_LOW, pick_word());
    cfg_write(REG_PATTERN_HIGH, pick_word());
    cfg_write(REG_CARE_MASK, v_care);
    cfg_write(REG_PATTERN_LEN, v_len);
    cfg_write(REG_REGION_BASE, v_base);
    if ($urandom_range(0, 4) == 0)
      cfg_write(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), rand64());
    cfg_release();
  endtask

  // one region, mostly with a planted pattern (sometimes with one cared byte
  // broken) so matches actually happen
  task scan_region();
    int          rlen;
    int          plen;
    int          mode;
    int          at;
    int          flip;
    int          pause_at;
    int          r;
    int          j;
    bit          alpha;
    bit          no_gaps;
    logic [7:0]  b;
    plen = sb.pattern_length;
    r    = $urandom_range(0, 99);
    if (r < 60)      rlen = $urandom_range(1, 20);
    else if (r < 90) rlen = $urandom_range(21, 48);
    else             rlen = $urandom_range(49, 80);
    mode = 0;
    if (plen >= 1 && plen <= PATTERN_MAX_DEFAULT && plen <= rlen) begin
      r = $urandom_range(0, 99);
      mode = (r < 60) ? 1 : (r < 80) ? 2 : 0;
    end
    at   = (mode != 0) ? $urandom_range(0, rlen - plen) : 0;
    flip = -1;
    if (mode == 2) begin
      j = $urandom_range(0, plen - 1);
      for (int k = 0; k < plen; k++) begin
        if (flip < 0 && sb.care_mask[(j + k) % plen]) flip = (j + k) % plen;
      end
    end
    alpha    = ($urandom_range(0, 2) == 0);
    no_gaps  = ($urandom_range(0, 3) == 0);
    pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, rlen - 1) : -1;
    for (int k = 0; k < rlen; k++) begin
      if (mode != 0 && k >= at && k < at + plen) begin
        j = k - at;
        b = sb.care_mask[j] ? sb.pattern_byte(j) : 8'($urandom);
        if (j == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
      end else if (alpha) begin
        r = $urandom_range(0, 9);
        if (r == 0)      b = 8'h00;
        else if (r == 1) b = 8'hFF;
        else             b = sb.pattern_byte($urandom_range(0, 15));
      end else begin
        b = 8'($urandom);
      end
      if (k == pause_at) wait_drain();
      send_byte(b, k == rlen - 1, no_gaps);
    end
  endtask

  task directed_checks();
    // empty pattern straight after reset
    send_byte(8'h00, 1'b1, 1'b0);
    wait_idle();
    // pattern ff ?? 00, care bits above the length set, junk in upper bits
    cfg_write(REG_PATTERN_LOW, 64'hA5A5_A5A5_A500_12FF);
    cfg_write(REG_PATTERN_HIGH, 64'h5A5A_5A5A_5A5A_5A5A);
    cfg_write(REG_CARE_MASK, 64'hDEAD_0000_0000_FFF5);
    cfg_write(REG_PATTERN_LEN, 64'h0000_0000_0000_00E3);
    cfg_write(REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
    cfg_write(REG_UNUSED_FIRST, 64'h0000_0000_0000_0001);
    cfg_release();
    // match completed by the last byte, address comes out as all ones
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h77, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    // region shorter than the pattern
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    // match at offset zero, second match not reported
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_drain();
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hAB, 1'b1, 1'b1);
    wait_idle();
    // single wildcard byte matches the first byte of the region
    cfg_write(REG_PATTERN_LEN, 64'h1);
    cfg_write(REG_CARE_MASK, 64'h0);
    cfg_release();
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.found, results_if.match_address);
  end

  // result side back-pressure
  initial begin
    int run;
    int gap;
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      results_if.ready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase;
    int stop_at;
    int target;
    sb                 = new();
    bytes_sent         = 0;
    rst                = 1'b1;
    bytes_if.valid     = 1'b0;
    bytes_if.data_byte = 8'h00;
    bytes_if.last_byte = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_checks();
    stop_at = bytes_sent + RANDOM_BYTES;
    phase   = 0;
    while (bytes_sent < stop_at) begin
      wait_idle();
      configure(phase);
      target = bytes_sent + $urandom_range(30, 90);
      while (bytes_sent < target) scan_region();
      phase++;
    end
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
